/* src/telemetry_frame_parser_macros.svh */
// assertion macros of the telemetry frame parser checker
// depends on a signal named clk, and for TFP_ASSERT also rst_n, in the scope of each use
`ifndef TELEMETRY_FRAME_PARSER_MACROS_SVH
`define TELEMETRY_FRAME_PARSER_MACROS_SVH

// property checked only while out of reset
`define TFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/tfp_pkg.sv */
// types and constants of the telemetry frame parser
// no dependencies
`default_nettype none

package tfp_pkg;

    // header and frame type bytes
    localparam logic [7:0] SYNC_DOLLAR = 8'h24;
    localparam logic [7:0] SYNC_T      = 8'h54;
    localparam logic [7:0] TYPE_GPS    = 8'h47;
    localparam logic [7:0] TYPE_ATT    = 8'h41;
    localparam logic [7:0] TYPE_STATUS = 8'h53;

    // frame kinds as reported
    localparam logic [1:0] KIND_GPS    = 2'd0;
    localparam logic [1:0] KIND_ATT    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // payload lengths: frame length minus header, type and checksum
    localparam logic [3:0] LEN_GPS    = 4'd14;
    localparam logic [3:0] LEN_ATT    = 4'd6;
    localparam logic [3:0] LEN_STATUS = 4'd7;

    localparam logic [15:0] HEADING_WRAP = 16'd360;

    // km/h = (ms*36+5)/10 folded into one constant multiply:
    // ((ms*36+5)*6554) >> 16 = (ms*235944 + 32770) >> 16, exact for ms < 256
    localparam logic [25:0] KMH_MUL = 26'd235944;
    localparam logic [25:0] KMH_ADD = 26'd32770;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]         frame_kind;
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
        logic signed [31:0] third_value;
        logic [7:0]         speed_ms;
        logic [9:0]         speed_kmh;
        logic [5:0]         satellites;
        logic [1:0]         fix_kind;
        logic [7:0]         signal_strength;
        logic [7:0]         air_speed;
        logic [1:0]         status_flags;
        logic [5:0]         flight_mode;
    } tfp_rec_t;

    function automatic logic [9:0] kmh_of(input logic [7:0] ms);
        logic [25:0] prod;
        prod = 26'(ms) * KMH_MUL + KMH_ADD;
        return prod[25:16];
    endfunction

endpackage

`default_nettype wire

/* src/tfp_if.sv */
// valid/ready channels of the telemetry frame parser
// depends on tfp_pkg for the record type
`default_nettype none

interface tfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfp_frame_if;
    logic             valid;
    logic             ready;
    tfp_pkg::tfp_rec_t rec;

    modport source (output valid, output rec, input ready);
    modport sink   (input valid, input rec, output ready);
endinterface

`default_nettype wire

/* src/tfp_front.sv */
// front end: header hunt, payload capture and checksum of one frame
// depends on tfp_pkg
`default_nettype none

module tfp_front #(
    parameter int MAX_PAYLOAD = 14
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     byte_valid,
    input  wire logic [7:0]               byte_data,
    output logic                          byte_ready,
    input  wire logic                     queue_full,
    output logic                          push,
    output logic [1:0]                    push_kind,
    output logic [MAX_PAYLOAD*8-1:0]      push_payload
);

    localparam int IDX_W = $clog2(MAX_PAYLOAD);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_START1 = 2'd1;
    localparam logic [1:0] PH_START2 = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [7:0] xor_reg, xor_next;
    logic [1:0] kind_reg, kind_next;
    logic [3:0] len_reg, len_next;
    logic [7:0] xor_new;
    logic       accept;
    logic       store_we;
    logic [7:0] store [MAX_PAYLOAD];

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign xor_new    = (cnt_reg == 4'd0) ? byte_data : (xor_reg ^ byte_data);
    assign store_we   = accept && (phase_reg == PH_DATA) && (cnt_reg < len_reg)
                        && (int'(cnt_reg) < MAX_PAYLOAD);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        push       = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (byte_data == tfp_pkg::SYNC_DOLLAR)
                        phase_next = PH_START1;
                end
                PH_START1:
                begin
                    phase_next = (byte_data == tfp_pkg::SYNC_T) ? PH_START2 : PH_IDLE;
                end
                PH_START2:
                begin
                    cnt_next   = 4'd0;
                    phase_next = PH_DATA;
                    case (byte_data)
                        tfp_pkg::TYPE_GPS:
                        begin
                            kind_next = tfp_pkg::KIND_GPS;
                            len_next  = tfp_pkg::LEN_GPS;
                        end
                        tfp_pkg::TYPE_ATT:
                        begin
                            kind_next = tfp_pkg::KIND_ATT;
                            len_next  = tfp_pkg::LEN_ATT;
                        end
                        tfp_pkg::TYPE_STATUS:
                        begin
                            kind_next = tfp_pkg::KIND_STATUS;
                            len_next  = tfp_pkg::LEN_STATUS;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                PH_DATA:
                begin
                    xor_next = xor_new;
                    if (cnt_reg >= len_reg)
                    begin
                        // checksum byte: good frame when everything cancels
                        phase_next = PH_IDLE;
                        push       = (xor_new == 8'd0);
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 4'd0;
            xor_reg   <= 8'd0;
            kind_reg  <= tfp_pkg::KIND_GPS;
            len_reg   <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
        end
    end

    // payload bytes, no reset: every byte a frame kind reads is written first
    always_ff @(posedge clk)
    begin
        if (store_we)
            store[cnt_reg[IDX_W-1:0]] <= byte_data;
    end

    assign push_kind = kind_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_PAYLOAD; i++)
            push_payload[i*8 +: 8] = store[i];
    end

endmodule

`default_nettype wire

/* src/tfp_queue.sv */
// short queue of checked frames between front and back end
// depends on tfp_pkg for the depth
`default_nettype none

module tfp_queue #(
    parameter int WIDTH = 114
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data
);

    localparam int DEPTH = tfp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;
    assign head_data  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* src/tfp_back.sv */
// back end: field decode of a checked frame into the result register
// depends on tfp_pkg
`default_nettype none

module tfp_back #(
    parameter int MAX_PAYLOAD = 14
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        head_valid,
    input  wire logic [1:0]                  head_kind,
    input  wire logic [MAX_PAYLOAD*8-1:0]    head_payload,
    output logic                             pop,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output tfp_pkg::tfp_rec_t                res_rec
);

    tfp_pkg::tfp_rec_t rec_reg, rec_next;
    logic              valid_reg, valid_next;
    logic [15:0]       heading;
    logic [7:0]        sats_fix;
    logic [7:0]        mode_byte;

    assign pop = head_valid && (!valid_reg || res_ready);

    always_comb
    begin
        heading   = head_payload[47:32];
        sats_fix  = head_payload[111:104];
        mode_byte = head_payload[55:48];
        if (heading[15])
            heading = heading + tfp_pkg::HEADING_WRAP;

        rec_next            = '0;
        rec_next.frame_kind = head_kind;
        case (head_kind)
            tfp_pkg::KIND_GPS:
            begin
                rec_next.first_value  = head_payload[31:0];
                rec_next.second_value = head_payload[63:32];
                rec_next.third_value  = head_payload[103:72];
                rec_next.speed_ms     = head_payload[71:64];
                rec_next.speed_kmh    = tfp_pkg::kmh_of(head_payload[71:64]);
                rec_next.satellites   = sats_fix[7:2];
                rec_next.fix_kind     = sats_fix[1:0];
            end
            tfp_pkg::KIND_ATT:
            begin
                rec_next.first_value  = 32'(signed'(head_payload[15:0]));
                rec_next.second_value = 32'(signed'(head_payload[31:16]));
                rec_next.third_value  = 32'(signed'(heading));
            end
            tfp_pkg::KIND_STATUS:
            begin
                rec_next.first_value     = {16'd0, head_payload[15:0]};
                rec_next.second_value    = {16'd0, head_payload[31:16]};
                rec_next.signal_strength = head_payload[39:32];
                rec_next.air_speed       = head_payload[47:40];
                rec_next.status_flags    = mode_byte[1:0];
                rec_next.flight_mode     = mode_byte[7:2];
            end
            default:
            begin
                rec_next.frame_kind = head_kind;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (res_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rec_reg <= rec_next;
    end

    assign res_valid = valid_reg;
    assign res_rec   = rec_reg;

endmodule

`default_nettype wire

/* src/telemetry_frame_parser.sv */
// top level of the telemetry frame parser: front end, frame queue, back end
// depends on tfp_pkg, tfp_if, tfp_front, tfp_queue, tfp_back
//
// usage
//   rx carries one received serial byte per transfer; result carries one
//   decoded record per frame whose header, type and checksum are good
//   frames start with '$' 'T' and a type byte (G gps, A attitude, S status),
//   then 14, 6 or 7 payload bytes and an xor checksum byte
//   broken headers, unknown types and bad checksums give no record
//   throughput: one byte per cycle, rx.ready stays high while the frame
//   queue has room
//   the record reaches result from the transfer of the checksum byte through
//   a queue slot and then the result register
//   when the receiver stalls, result holds its record and up to two more
//   checked frames wait in the queue; only then does rx.ready drop
//   reset: parser back to hunting for '$', queue empty, result.valid low
//   fields that do not apply to the frame kind read as zero
`default_nettype none

module telemetry_frame_parser #(
    parameter int MAX_PAYLOAD = 14
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tfp_byte_if.sink     rx,
    tfp_frame_if.source  result
);

    localparam int ENTRY_W = 2 + MAX_PAYLOAD * 8;

    // front end to queue
    logic                       push;
    logic [1:0]                 push_kind;
    logic [MAX_PAYLOAD*8-1:0]   push_payload;
    logic                       queue_full;

    // queue to back end
    logic                       pop;
    logic                       head_valid;
    logic [ENTRY_W-1:0]         head_data;

    // header hunt, payload capture and checksum
    tfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (rx.valid),
        .byte_data    (rx.rx_byte),
        .byte_ready   (rx.ready),
        .queue_full   (queue_full),
        .push         (push),
        .push_kind    (push_kind),
        .push_payload (push_payload)
    );

    // checked frames waiting for the back end
    tfp_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_kind, push_payload}),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // field decode and result register
    tfp_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_kind    (head_data[ENTRY_W-1 -: 2]),
        .head_payload (head_data[MAX_PAYLOAD*8-1:0]),
        .pop          (pop),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .res_rec      (result.rec)
    );

endmodule

`default_nettype wire

/* src/tfp_checker.sv */
// port-level checks of the telemetry frame parser, bound to the top level
// depends on tfp_pkg and telemetry_frame_parser_macros.svh
`default_nettype none
`include "telemetry_frame_parser_macros.svh"

module tfp_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              rx_valid,
    input wire logic              rx_ready,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire tfp_pkg::tfp_rec_t res_rec
);

    logic rx_xfer;
    logic res_stall;
    logic other_than_gps;
    logic other_than_status;
    logic gps_clear;
    logic status_clear;

    assign rx_xfer           = rx_valid && rx_ready;
    assign res_stall         = res_valid && !res_ready;
    assign other_than_gps    = res_valid && (res_rec.frame_kind != tfp_pkg::KIND_GPS);
    assign other_than_status = res_valid && (res_rec.frame_kind != tfp_pkg::KIND_STATUS);
    assign gps_clear         = (res_rec.speed_ms == 8'd0) && (res_rec.speed_kmh == 10'd0)
                               && (res_rec.satellites == 6'd0) && (res_rec.fix_kind == 2'd0);
    assign status_clear      = (res_rec.signal_strength == 8'd0) && (res_rec.air_speed == 8'd0)
                               && (res_rec.status_flags == 2'd0) && (res_rec.flight_mode == 6'd0);

    // a stalled record holds
    `TFP_ASSERT(a_res_hold, res_stall |=> res_valid && $stable(res_rec), "stalled result changed")

    // a new record follows a byte transfer by the pipeline delay
    `TFP_ASSERT(a_res_cause, $rose(res_valid) |-> $past(rx_xfer, 2), "record without checksum byte")

    // gps-only fields are zero for other frames
    `TFP_ASSERT(a_gps_zero, other_than_gps |-> gps_clear, "gps field set outside gps frame")

    // status-only fields are zero for other frames
    `TFP_ASSERT(a_status_zero, other_than_status |-> status_clear, "status field outside status frame")

    // result valid low while in reset
    `TFP_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !res_valid, "result valid during reset")

endmodule

bind telemetry_frame_parser tfp_checker u_tfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_rec   (result.rec)
);

`default_nettype wire
